// File: rtl/tbpe_pkg.sv
// Shared types, widths, constants and tables of the binomial trigonometric polynomial evaluator.
`timescale 1ns / 1ps
package tbpe_pkg;

  // Defaults of the top-level parameters.
  localparam int MAX_DEGREE_DEF     = 6;
  localparam int ANGLE_BITS_DEF     = 16;
  localparam int SINGULAR_LIMIT_DEF = 1;

  // Register map.
  localparam int NCOEF  = 7;
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_DEGREE = 3'd0;

  // Fixed-point constants.
  localparam int FRAC = 15;
  localparam int HALF = 16384;
  localparam int ONE  = 32768;

  // Rotation datapath.
  localparam int CORDIC_STEPS = 28;
  localparam int XY_W         = 34;
  localparam int Z_W          = 32;
  localparam int CORDIC_GAIN  = 652032874;

  // Datapath widths.
  localparam int PW_W   = 17;
  localparam int BT_W   = 23;
  localparam int G_W    = 55;
  localparam int W_W    = 20;
  localparam int CS_W   = 34;
  localparam int RG_W   = 40;
  localparam int P_W    = 60;
  localparam int NV_W   = 58;
  localparam int ND_W   = 63;
  localparam int VAL_W  = 48;
  localparam int N_W    = 62;
  localparam int D_W    = 31;
  localparam int Q_W    = 48;
  localparam int OVF_SH = Q_W - FRAC;
  localparam int REM_W  = N_W + FRAC + 2;

  typedef logic signed [PW_W-1:0] pw_t;

  // Side information that travels through the divider with each quotient.
  typedef struct packed {
    logic                    sing;
    logic                    neg;
    logic                    ovf;
    logic signed [VAL_W-1:0] value;
  } div_side_t;

  // One finished result.
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] slope;
    logic                    singular;
    logic                    saturated;
  } result_t;

  // Binomial coefficients C(k, i) for k up to six.
  localparam logic [4:0] BINOM_TBL [0:6][0:6] = '{
    '{5'd1, 5'd0, 5'd0,  5'd0,  5'd0,  5'd0, 5'd0},
    '{5'd1, 5'd1, 5'd0,  5'd0,  5'd0,  5'd0, 5'd0},
    '{5'd1, 5'd2, 5'd1,  5'd0,  5'd0,  5'd0, 5'd0},
    '{5'd1, 5'd3, 5'd3,  5'd1,  5'd0,  5'd0, 5'd0},
    '{5'd1, 5'd4, 5'd6,  5'd4,  5'd1,  5'd0, 5'd0},
    '{5'd1, 5'd5, 5'd10, 5'd10, 5'd5,  5'd1, 5'd0},
    '{5'd1, 5'd6, 5'd15, 5'd20, 5'd15, 5'd6, 5'd1}
  };

  function automatic logic [4:0] binom(input logic [2:0] k, input logic [2:0] i);
    logic [4:0] r;
    if (k > 3'd6 || i > 3'd6) begin
      r = '0;
    end else begin
      r = BINOM_TBL[k][i];
    end
    return r;
  endfunction

  // Arctangent of 2^-j as a fraction of a full turn scaled by 2^32.
  function automatic logic signed [Z_W-1:0] atan_turn(input int j);
    logic signed [Z_W-1:0] r;
    case (j)
      0:  r = 32'sd536870912;
      1:  r = 32'sd316933406;
      2:  r = 32'sd167458907;
      3:  r = 32'sd85004756;
      4:  r = 32'sd42667331;
      5:  r = 32'sd21354465;
      6:  r = 32'sd10679838;
      7:  r = 32'sd5340245;
      8:  r = 32'sd2670163;
      9:  r = 32'sd1335087;
      10: r = 32'sd667544;
      11: r = 32'sd333772;
      12: r = 32'sd166886;
      13: r = 32'sd83443;
      14: r = 32'sd41722;
      15: r = 32'sd20861;
      16: r = 32'sd10430;
      17: r = 32'sd5215;
      18: r = 32'sd2608;
      19: r = 32'sd1304;
      20: r = 32'sd652;
      21: r = 32'sd326;
      22: r = 32'sd163;
      23: r = 32'sd81;
      24: r = 32'sd41;
      25: r = 32'sd20;
      26: r = 32'sd10;
      27: r = 32'sd5;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/tbpe_cordic.sv
// Pipelined CORDIC rotator: one micro-rotation per register stage.
`timescale 1ns / 1ps
module tbpe_cordic (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                in_v,
  input  logic [31:0]                         in_phase,
  output logic                                out_v,
  output logic signed [tbpe_pkg::XY_W-1:0]    out_x,
  output logic signed [tbpe_pkg::XY_W-1:0]    out_y,
  output logic [1:0]                          out_q
);
  import tbpe_pkg::*;

  logic [CORDIC_STEPS-1:0] v_r;
  logic signed [XY_W-1:0]  x_r   [CORDIC_STEPS];
  logic signed [XY_W-1:0]  y_r   [CORDIC_STEPS];
  logic signed [Z_W-1:0]   z_r   [CORDIC_STEPS];
  logic [1:0]              q_r   [CORDIC_STEPS];
  logic signed [XY_W-1:0]  x_in  [CORDIC_STEPS];
  logic signed [XY_W-1:0]  y_in  [CORDIC_STEPS];
  logic signed [Z_W-1:0]   z_in  [CORDIC_STEPS];
  logic signed [XY_W-1:0]  x_nxt [CORDIC_STEPS];
  logic signed [XY_W-1:0]  y_nxt [CORDIC_STEPS];
  logic signed [Z_W-1:0]   z_nxt [CORDIC_STEPS];

  // Stage inputs: the first stage starts from the gain-compensated unit vector.
  always_comb begin
    x_in[0] = XY_W'(CORDIC_GAIN);
    y_in[0] = '0;
    z_in[0] = Z_W'({2'b00, in_phase[29:0]});
    for (int j = 1; j < CORDIC_STEPS; j++) begin
      x_in[j] = x_r[j-1];
      y_in[j] = y_r[j-1];
      z_in[j] = z_r[j-1];
    end
  end

  // One micro-rotation per stage, direction set by the sign of the residual angle.
  always_comb begin
    for (int j = 0; j < CORDIC_STEPS; j++) begin
      if (!z_in[j][Z_W-1]) begin
        x_nxt[j] = x_in[j] - (y_in[j] >>> j);
        y_nxt[j] = y_in[j] + (x_in[j] >>> j);
        z_nxt[j] = z_in[j] - atan_turn(j);
      end else begin
        x_nxt[j] = x_in[j] + (y_in[j] >>> j);
        y_nxt[j] = y_in[j] - (x_in[j] >>> j);
        z_nxt[j] = z_in[j] + atan_turn(j);
      end
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[CORDIC_STEPS-2:0], in_v};
    end
  end

  // Stage data registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      q_r[0] <= in_phase[31:30];
      for (int j = 1; j < CORDIC_STEPS; j++) begin
        q_r[j] <= q_r[j-1];
      end
      for (int j = 0; j < CORDIC_STEPS; j++) begin
        x_r[j] <= x_nxt[j];
        y_r[j] <= y_nxt[j];
        z_r[j] <= z_nxt[j];
      end
    end
  end

  assign out_v = v_r[CORDIC_STEPS-1];
  assign out_x = x_r[CORDIC_STEPS-1];
  assign out_y = y_r[CORDIC_STEPS-1];
  assign out_q = q_r[CORDIC_STEPS-1];

endmodule

// File: rtl/tbpe_div.sv
// Pipelined restoring divider: one quotient bit per register stage.
`timescale 1ns / 1ps
module tbpe_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_v,
  input  logic [tbpe_pkg::N_W-1:0]      in_num,
  input  logic [tbpe_pkg::D_W-1:0]      in_den,
  input  tbpe_pkg::div_side_t           in_side,
  output logic                          out_v,
  output logic [tbpe_pkg::Q_W-1:0]      out_q,
  output tbpe_pkg::div_side_t           out_side
);
  import tbpe_pkg::*;

  logic [Q_W-1:0]   v_r;
  logic [REM_W-1:0] rem_r   [Q_W];
  logic [Q_W-1:0]   q_r     [Q_W];
  logic [D_W-1:0]   den_r   [Q_W];
  div_side_t        side_r  [Q_W];
  logic [REM_W-1:0] rem_in  [Q_W];
  logic [Q_W-1:0]   q_in    [Q_W];
  logic [D_W-1:0]   den_in  [Q_W];
  logic [REM_W-1:0] rem_nxt [Q_W];
  logic [Q_W-1:0]   q_nxt   [Q_W];

  // Stage inputs: the numerator enters pre-scaled by the fraction bits.
  always_comb begin
    rem_in[0] = REM_W'({in_num, {FRAC{1'b0}}});
    q_in[0]   = '0;
    den_in[0] = in_den;
    for (int j = 1; j < Q_W; j++) begin
      rem_in[j] = rem_r[j-1];
      q_in[j]   = q_r[j-1];
      den_in[j] = den_r[j-1];
    end
  end

  // Trial subtraction of the shifted divisor, most significant quotient bit first.
  always_comb begin
    logic [REM_W-1:0] sub;
    logic [REM_W:0]   diff;
    for (int j = 0; j < Q_W; j++) begin
      sub  = REM_W'(den_in[j]) << (Q_W - 1 - j);
      diff = {1'b0, rem_in[j]} - {1'b0, sub};
      if (!diff[REM_W]) begin
        rem_nxt[j] = diff[REM_W-1:0];
        q_nxt[j]   = {q_in[j][Q_W-2:0], 1'b1};
      end else begin
        rem_nxt[j] = rem_in[j];
        q_nxt[j]   = {q_in[j][Q_W-2:0], 1'b0};
      end
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[Q_W-2:0], in_v};
    end
  end

  // Stage data registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= in_side;
      for (int j = 1; j < Q_W; j++) begin
        side_r[j] <= side_r[j-1];
      end
      for (int j = 0; j < Q_W; j++) begin
        rem_r[j] <= rem_nxt[j];
        q_r[j]   <= q_nxt[j];
        den_r[j] <= den_in[j];
      end
    end
  end

  assign out_v    = v_r[Q_W-1];
  assign out_q    = q_r[Q_W-1];
  assign out_side = side_r[Q_W-1];

endmodule

// File: rtl/trig_binomial_poly_eval.sv
// Top level of the binomial trigonometric polynomial evaluator.
`timescale 1ns / 1ps
// The block takes one angle per cycle while in_stall is low and returns
// the value F = sum C(k,i) cos^i sin^(k-i) coef_i and its slope dF/dX
// in signed Q32.16, with a singular flag (results forced to zero when |cos| or
// |sin| falls at or below SINGULAR_LIMIT) and a saturated flag. The pipeline
// is made of the 28-stage CORDIC, the power, product and adder-tree stages (16 in
// all) and the 48-stage restoring divider that forms the slope; every stage is
// one register, so a new angle can follow in each cycle while in_stall is low.
// An output register and a one-entry skid buffer decouple the two channels:
// in_stall rises only when a result is waiting in the skid buffer.
// Configuration registers must be written while no transaction is in flight.
module trig_binomial_poly_eval #(
  parameter int MAX_DEGREE     = tbpe_pkg::MAX_DEGREE_DEF,
  parameter int ANGLE_BITS     = tbpe_pkg::ANGLE_BITS_DEF,
  parameter int SINGULAR_LIMIT = tbpe_pkg::SINGULAR_LIMIT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [15:0]                       in_angle,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [tbpe_pkg::VAL_W-1:0] out_value,
  output logic signed [tbpe_pkg::VAL_W-1:0] out_slope,
  output logic                              out_singular,
  output logic                              out_saturated,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [tbpe_pkg::ADDR_W-1:0]       cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);
  import tbpe_pkg::*;

  localparam int NPW = NCOEF - 2;
  localparam logic [31:0] ANG_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);
  localparam logic [2:0] MAXD = 3'(MAX_DEGREE);
  localparam pw_t SING_LIM = PW_W'(SINGULAR_LIMIT);
  localparam logic signed [XY_W-1:0] Q15_MAX = XY_W'(32767);
  localparam logic signed [XY_W-1:0] Q15_MIN = -XY_W'(32767);
  localparam logic [VAL_W-1:0] LIM_POS = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] LIM_NEG = {1'b1, {(VAL_W-1){1'b0}}};

  // ---------------- configuration registers ----------------
  logic [2:0]         degree_r;
  logic signed [31:0] coef_r [NCOEF];
  logic [2:0]         cfg_idx;
  logic [2:0]         kc;

  assign cfg_idx    = cfg_paddr[ADDR_W-1:2];
  assign cfg_pready = 1'b1;

  // Register writes on the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= '0;
      for (int i = 0; i < NCOEF; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_idx == REG_DEGREE) begin
        degree_r <= cfg_pwdata[2:0];
      end else begin
        coef_r[cfg_idx - 3'd1] <= cfg_pwdata;
      end
    end
  end

  // Register read-back.
  always_comb begin
    if (cfg_idx == REG_DEGREE) begin
      cfg_prdata = {29'b0, degree_r};
    end else begin
      cfg_prdata = coef_r[cfg_idx - 3'd1];
    end
  end

  // Effective polynomial order.
  assign kc = (degree_r > MAXD) ? MAXD : degree_r;

  // ---------------- stage control ----------------
  logic    adv;
  logic    sk_v_r, sk_v_nxt;
  result_t sk_r, sk_nxt;
  logic    out_v_r, out_v_nxt;
  result_t out_r, out_nxt;

  assign adv      = !sk_v_r;
  assign in_stall = sk_v_r;

  // ---------------- CORDIC ----------------
  logic [31:0]            phase;
  logic                   cd_v;
  logic signed [XY_W-1:0] cd_x, cd_y;
  logic [1:0]             cd_q;

  assign phase = ({16'b0, in_angle} & ANG_MASK) << (32 - ANGLE_BITS);

  tbpe_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (in_valid),
    .in_phase (phase),
    .out_v    (cd_v),
    .out_x    (cd_x),
    .out_y    (cd_y),
    .out_q    (cd_q)
  );

  // ---------------- quadrant, Q1.15 conversion, singular test ----------------
  logic                   s1_v_r;
  pw_t                    s1_c_r, s1_s_r;
  logic                   s1_sing_r;
  pw_t                    s1_c_nxt, s1_s_nxt;
  logic                   s1_sing_nxt;

  always_comb begin
    logic signed [XY_W-1:0] cc, ss, rc, rs;
    case (cd_q)
      2'd0: begin cc = cd_x;  ss = cd_y;  end
      2'd1: begin cc = -cd_y; ss = cd_x;  end
      2'd2: begin cc = -cd_x; ss = -cd_y; end
      default: begin cc = cd_y; ss = -cd_x; end
    endcase
    rc = (cc + XY_W'(HALF)) >>> FRAC;
    rs = (ss + XY_W'(HALF)) >>> FRAC;
    if (rc > Q15_MAX) rc = Q15_MAX;
    if (rc < Q15_MIN) rc = Q15_MIN;
    if (rs > Q15_MAX) rs = Q15_MAX;
    if (rs < Q15_MIN) rs = Q15_MIN;
    s1_c_nxt    = rc[PW_W-1:0];
    s1_s_nxt    = rs[PW_W-1:0];
    s1_sing_nxt = (s1_c_nxt <= SING_LIM && s1_c_nxt >= -SING_LIM) ||
                  (s1_s_nxt <= SING_LIM && s1_s_nxt >= -SING_LIM);
  end

  // ---------------- power stages: one new power of cos and sin each ----------------
  logic [NPW-1:0] pw_v_r;
  pw_t  pw_cp_r  [NPW][NCOEF];
  pw_t  pw_sp_r  [NPW][NCOEF];
  pw_t  pw_c_r   [NPW];
  pw_t  pw_s_r   [NPW];
  logic pw_sing_r[NPW];
  pw_t  cp_in    [NPW][NCOEF];
  pw_t  sp_in    [NPW][NCOEF];
  pw_t  pc_in    [NPW];
  pw_t  ps_in    [NPW];
  pw_t  cp_nxt   [NPW][NCOEF];
  pw_t  sp_nxt   [NPW][NCOEF];

  always_comb begin
    for (int i = 0; i < NCOEF; i++) begin
      cp_in[0][i] = '0;
      sp_in[0][i] = '0;
    end
    cp_in[0][0] = PW_W'(ONE);
    sp_in[0][0] = PW_W'(ONE);
    cp_in[0][1] = s1_c_r;
    sp_in[0][1] = s1_s_r;
    pc_in[0]    = s1_c_r;
    ps_in[0]    = s1_s_r;
    for (int n = 1; n < NPW; n++) begin
      cp_in[n] = pw_cp_r[n-1];
      sp_in[n] = pw_sp_r[n-1];
      pc_in[n] = pw_c_r[n-1];
      ps_in[n] = pw_s_r[n-1];
    end
  end

  always_comb begin
    logic signed [2*PW_W-1:0] pc, ps;
    for (int n = 0; n < NPW; n++) begin
      cp_nxt[n] = cp_in[n];
      sp_nxt[n] = sp_in[n];
      pc = cp_in[n][n+1] * pc_in[n];
      ps = sp_in[n][n+1] * ps_in[n];
      pc = (pc + (2*PW_W)'(HALF)) >>> FRAC;
      ps = (ps + (2*PW_W)'(HALF)) >>> FRAC;
      cp_nxt[n][n+2] = pc[PW_W-1:0];
      sp_nxt[n][n+2] = ps[PW_W-1:0];
    end
  end

  // ---------------- monomials cos^i * sin^(k-i) ----------------
  logic m_v_r;
  pw_t  m_t_r [NCOEF];
  pw_t  m_c2_r, m_c_r, m_s_r;
  logic m_sing_r;
  pw_t  m_t_nxt [NCOEF];

  always_comb begin
    logic signed [2*PW_W-1:0] pm;
    logic [2:0]               si;
    for (int i = 0; i < NCOEF; i++) begin
      si = kc - 3'(i);
      pm = pw_cp_r[NPW-1][i] * pw_sp_r[NPW-1][si];
      pm = (pm + (2*PW_W)'(HALF)) >>> FRAC;
      m_t_nxt[i] = (3'(i) <= kc) ? pm[PW_W-1:0] : '0;
    end
  end

  // ---------------- binomial weighting ----------------
  logic                   b_v_r;
  logic signed [BT_W-1:0] b_bt_r [NCOEF];
  pw_t                    b_c2_r, b_c_r, b_s_r;
  logic                   b_sing_r;
  logic signed [BT_W-1:0] b_bt_nxt [NCOEF];

  always_comb begin
    for (int i = 0; i < NCOEF; i++) begin
      b_bt_nxt[i] = $signed({1'b0, binom(kc, 3'(i))}) * m_t_r[i];
    end
  end

  // ---------------- coefficient products, slope weights, cos*sin ----------------
  logic                   g_v_r;
  logic signed [G_W-1:0]  g_g_r [NCOEF];
  logic signed [W_W-1:0]  g_w_r [NCOEF];
  logic signed [CS_W-1:0] g_cs_r;
  logic                   g_sing_r;
  logic signed [G_W-1:0]  g_g_nxt [NCOEF];
  logic signed [W_W-1:0]  g_w_nxt [NCOEF];
  logic signed [CS_W-1:0] g_cs_nxt;

  always_comb begin
    logic signed [W_W-1:0] kw;
    kw = $signed({1'b0, kc}) * b_c2_r;
    for (int i = 0; i < NCOEF; i++) begin
      g_g_nxt[i] = b_bt_r[i] * coef_r[i];
      g_w_nxt[i] = kw - W_W'(i * ONE);
    end
    g_cs_nxt = b_c_r * b_s_r;
  end

  // ---------------- rounding of each term to Q16 ----------------
  logic                   r_v_r;
  logic signed [G_W-1:0]  r_g_r  [NCOEF];
  logic signed [RG_W-1:0] r_rg_r [NCOEF];
  logic signed [W_W-1:0]  r_w_r  [NCOEF];
  logic signed [CS_W-1:0] r_cs_r;
  logic                   r_sing_r;
  logic signed [RG_W-1:0] r_rg_nxt [NCOEF];

  always_comb begin
    logic signed [G_W-1:0] rt;
    for (int i = 0; i < NCOEF; i++) begin
      rt = (g_g_r[i] + G_W'(HALF)) >>> FRAC;
      r_rg_nxt[i] = rt[RG_W-1:0];
    end
  end

  // ---------------- slope numerator terms ----------------
  logic                   d_v_r;
  logic signed [G_W-1:0]  d_g_r [NCOEF];
  logic signed [P_W-1:0]  d_p_r [NCOEF];
  logic signed [CS_W-1:0] d_cs_r;
  logic                   d_sing_r;
  logic signed [P_W-1:0]  d_p_nxt [NCOEF];

  always_comb begin
    for (int i = 0; i < NCOEF; i++) begin
      d_p_nxt[i] = r_rg_r[i] * r_w_r[i];
    end
  end

  // ---------------- adder tree, three levels ----------------
  logic                   t1_v_r, t2_v_r, t3_v_r;
  logic signed [NV_W-1:0] t1_nv_r [4];
  logic signed [ND_W-1:0] t1_nd_r [4];
  logic signed [NV_W-1:0] t2_nv_r [2];
  logic signed [ND_W-1:0] t2_nd_r [2];
  logic signed [NV_W-1:0] t3_nv_r;
  logic signed [ND_W-1:0] t3_nd_r;
  logic signed [CS_W-1:0] t1_cs_r, t2_cs_r, t3_cs_r;
  logic                   t1_sing_r, t2_sing_r, t3_sing_r;

  // ---------------- value rounding, sign and magnitudes for the divider ----------------
  logic                    f_v_r;
  logic signed [VAL_W-1:0] f_val_r;
  logic [N_W-1:0]          f_n_r;
  logic [D_W-1:0]          f_d_r;
  logic                    f_neg_r, f_sing_r;
  logic signed [VAL_W-1:0] f_val_nxt;
  logic [N_W-1:0]          f_n_nxt;
  logic [D_W-1:0]          f_d_nxt;

  // The value sum stays far inside the output range, so it is never clipped.
  always_comb begin
    logic signed [NV_W-1:0] vr;
    logic signed [ND_W-1:0] na;
    logic signed [CS_W-1:0] da;
    vr        = (t3_nv_r + NV_W'(HALF)) >>> FRAC;
    na        = t3_nd_r[ND_W-1] ? -t3_nd_r : t3_nd_r;
    da        = t3_cs_r[CS_W-1] ? -t3_cs_r : t3_cs_r;
    f_val_nxt = vr[VAL_W-1:0];
    f_n_nxt   = na[N_W-1:0];
    f_d_nxt   = da[D_W-1:0];
  end

  // ---------------- quotient overflow check ----------------
  logic           o_v_r;
  logic [N_W-1:0] o_n_r;
  logic [D_W-1:0] o_d_r;
  div_side_t      o_side_r;
  logic           o_ovf_nxt;

  assign o_ovf_nxt = {2'b00, f_n_r} >= {f_d_r, {OVF_SH{1'b0}}};

  // ---------------- pipeline valid bits ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      pw_v_r <= '0;
      m_v_r  <= 1'b0;
      b_v_r  <= 1'b0;
      g_v_r  <= 1'b0;
      r_v_r  <= 1'b0;
      d_v_r  <= 1'b0;
      t1_v_r <= 1'b0;
      t2_v_r <= 1'b0;
      t3_v_r <= 1'b0;
      f_v_r  <= 1'b0;
      o_v_r  <= 1'b0;
    end else if (adv) begin
      s1_v_r <= cd_v;
      pw_v_r <= {pw_v_r[NPW-2:0], s1_v_r};
      m_v_r  <= pw_v_r[NPW-1];
      b_v_r  <= m_v_r;
      g_v_r  <= b_v_r;
      r_v_r  <= g_v_r;
      d_v_r  <= r_v_r;
      t1_v_r <= d_v_r;
      t2_v_r <= t1_v_r;
      t3_v_r <= t2_v_r;
      f_v_r  <= t3_v_r;
      o_v_r  <= f_v_r;
    end
  end

  // ---------------- pipeline data registers ----------------
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_c_r    <= s1_c_nxt;
      s1_s_r    <= s1_s_nxt;
      s1_sing_r <= s1_sing_nxt;

      pw_sing_r[0] <= s1_sing_r;
      for (int n = 1; n < NPW; n++) begin
        pw_sing_r[n] <= pw_sing_r[n-1];
      end
      for (int n = 0; n < NPW; n++) begin
        pw_cp_r[n] <= cp_nxt[n];
        pw_sp_r[n] <= sp_nxt[n];
        pw_c_r[n]  <= pc_in[n];
        pw_s_r[n]  <= ps_in[n];
      end

      m_t_r    <= m_t_nxt;
      m_c2_r   <= pw_cp_r[NPW-1][2];
      m_c_r    <= pw_c_r[NPW-1];
      m_s_r    <= pw_s_r[NPW-1];
      m_sing_r <= pw_sing_r[NPW-1];

      b_bt_r   <= b_bt_nxt;
      b_c2_r   <= m_c2_r;
      b_c_r    <= m_c_r;
      b_s_r    <= m_s_r;
      b_sing_r <= m_sing_r;

      g_g_r    <= g_g_nxt;
      g_w_r    <= g_w_nxt;
      g_cs_r   <= g_cs_nxt;
      g_sing_r <= b_sing_r;

      r_g_r    <= g_g_r;
      r_rg_r   <= r_rg_nxt;
      r_w_r    <= g_w_r;
      r_cs_r   <= g_cs_r;
      r_sing_r <= g_sing_r;

      d_g_r    <= r_g_r;
      d_p_r    <= d_p_nxt;
      d_cs_r   <= r_cs_r;
      d_sing_r <= r_sing_r;

      for (int i = 0; i < 3; i++) begin
        t1_nv_r[i] <= NV_W'(d_g_r[2*i]) + NV_W'(d_g_r[2*i+1]);
        t1_nd_r[i] <= ND_W'(d_p_r[2*i]) + ND_W'(d_p_r[2*i+1]);
      end
      t1_nv_r[3] <= NV_W'(d_g_r[6]);
      t1_nd_r[3] <= ND_W'(d_p_r[6]);
      t1_cs_r    <= d_cs_r;
      t1_sing_r  <= d_sing_r;

      for (int i = 0; i < 2; i++) begin
        t2_nv_r[i] <= t1_nv_r[2*i] + t1_nv_r[2*i+1];
        t2_nd_r[i] <= t1_nd_r[2*i] + t1_nd_r[2*i+1];
      end
      t2_cs_r   <= t1_cs_r;
      t2_sing_r <= t1_sing_r;

      t3_nv_r   <= t2_nv_r[0] + t2_nv_r[1];
      t3_nd_r   <= t2_nd_r[0] + t2_nd_r[1];
      t3_cs_r   <= t2_cs_r;
      t3_sing_r <= t2_sing_r;

      f_val_r  <= f_val_nxt;
      f_n_r    <= f_n_nxt;
      f_d_r    <= f_d_nxt;
      f_neg_r  <= t3_nd_r[ND_W-1] ^ t3_cs_r[CS_W-1];
      f_sing_r <= t3_sing_r;

      o_n_r          <= f_n_r;
      o_d_r          <= f_d_r;
      o_side_r.sing  <= f_sing_r;
      o_side_r.neg   <= f_neg_r;
      o_side_r.ovf   <= o_ovf_nxt;
      o_side_r.value <= f_val_r;
    end
  end

  // ---------------- slope division ----------------
  logic           dv_v;
  logic [Q_W-1:0] dv_q;
  div_side_t      dv_side;

  tbpe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (o_v_r),
    .in_num   (o_n_r),
    .in_den   (o_d_r),
    .in_side  (o_side_r),
    .out_v    (dv_v),
    .out_q    (dv_q),
    .out_side (dv_side)
  );

  // ---------------- slope clipping and sign, singular override ----------------
  result_t pipe_res;

  always_comb begin
    logic [VAL_W-1:0] lim, mag;
    logic             sat;
    lim = dv_side.neg ? LIM_NEG : LIM_POS;
    sat = dv_side.ovf || (dv_q > lim);
    mag = sat ? lim : dv_q;
    if (dv_side.sing) begin
      pipe_res.value     = '0;
      pipe_res.slope     = '0;
      pipe_res.singular  = 1'b1;
      pipe_res.saturated = 1'b0;
    end else begin
      pipe_res.value     = dv_side.value;
      pipe_res.slope     = dv_side.neg ? -mag : mag;
      pipe_res.singular  = 1'b0;
      pipe_res.saturated = sat;
    end
  end

  // ---------------- output register and skid buffer ----------------
  always_comb begin
    logic leave;
    leave     = dv_v && adv;
    out_v_nxt = out_v_r;
    out_nxt   = out_r;
    sk_v_nxt  = sk_v_r;
    sk_nxt    = sk_r;
    if (!out_v_r || !out_stall) begin
      if (sk_v_r) begin
        out_v_nxt = 1'b1;
        out_nxt   = sk_r;
        sk_v_nxt  = 1'b0;
      end else if (leave) begin
        out_v_nxt = 1'b1;
        out_nxt   = pipe_res;
      end else begin
        out_v_nxt = 1'b0;
      end
    end else if (leave) begin
      sk_v_nxt = 1'b1;
      sk_nxt   = pipe_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      sk_v_r  <= sk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    sk_r  <= sk_nxt;
  end

  assign out_valid     = out_v_r;
  assign out_value     = out_r.value;
  assign out_slope     = out_r.slope;
  assign out_singular  = out_r.singular;
  assign out_saturated = out_r.saturated;

  // ---------------- assertions ----------------
  // The skid buffer only fills behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    sk_v_r |-> out_v_r)
    else $error("skid buffer holds a result while the output register is empty");

  // A taken output drains the skid buffer into the output register.
  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (sk_v_r && !out_stall) |=> (out_v_r && !sk_v_r))
    else $error("skid buffer did not drain after the output was taken");

  // Singular results carry zero values and no saturation.
  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.singular) |->
      (out_r.value == '0 && out_r.slope == '0 && !out_r.saturated))
    else $error("singular result with nonzero payload");

  // A saturated slope sits at one of the range limits.
  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.saturated) |->
      (out_r.slope == $signed(LIM_POS) || out_r.slope == $signed(LIM_NEG)))
    else $error("saturated flag set but slope is not at a limit");

endmodule
